[src/cfpf_pkg.sv]
// ----------------------------------------------------------------------------
// cfpf_pkg
// Shared types and constants for the contour fingertip peak finder.
// ----------------------------------------------------------------------------
package cfpf_pkg;

   localparam int CSR_ADDR_BITS = 2;
   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;

   // register indexes
   localparam csr_addr_type CSR_CENTER_X       = 2'd0;
   localparam csr_addr_type CSR_CENTER_Y       = 2'd1;
   localparam csr_addr_type CSR_HOLD_LIMIT     = 2'd2;
   localparam csr_addr_type CSR_MIN_SEPARATION = 2'd3;

   localparam int HOLD_BITS = 8;
   typedef logic [HOLD_BITS-1:0] hold_type;

   localparam hold_type HOLD_LIMIT_RESET = 8'd40;
   localparam int       MIN_SEP_RESET    = 20;

endpackage

[src/cfpf_tip_cell.sv]
// ----------------------------------------------------------------------------
// cfpf_tip_cell
// One slot of the tip list: holds a tip column, shifts it on a push and
// folds its own closeness test into the running near flag.
// ----------------------------------------------------------------------------
module cfpf_tip_cell #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic                  active,
   input  logic                  near_prev,
   input  logic [COORD_BITS-1:0] prev_col,
   input  logic [COORD_BITS-1:0] cand_x,
   input  logic [COORD_BITS-1:0] min_sep,
   output logic [COORD_BITS-1:0] next_col,
   output logic                  near_next
);

   logic [COORD_BITS-1:0] col_ff;
   logic [COORD_BITS-1:0] col_in;
   logic [COORD_BITS-1:0] diff;

   assign col_in = shift_en ? prev_col : col_ff;

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign diff      = (col_ff > cand_x) ? (col_ff - cand_x) : (cand_x - col_ff);
   assign next_col  = col_ff;
   assign near_next = near_prev | (active & (diff < min_sep));

endmodule

[src/cfpf_tip_chain.sv]
// ----------------------------------------------------------------------------
// cfpf_tip_chain
// Row of tip cells. A push shifts every column one cell down the row and
// loads the candidate into the first cell; only the first tip_count cells
// take part in the closeness test.
// ----------------------------------------------------------------------------
module cfpf_tip_chain #(
   parameter int MAX_TIPS   = 8,
   parameter int COORD_BITS = 12,
   parameter int CNT_BITS   = 4
) (
   input  logic                  clock,
   input  logic                  push,
   input  logic [CNT_BITS-1:0]   tip_count,
   input  logic [COORD_BITS-1:0] cand_x,
   input  logic [COORD_BITS-1:0] min_sep,
   output logic                  near
);

   logic [COORD_BITS-1:0] col_link  [MAX_TIPS+1];
   logic                  near_link [MAX_TIPS+1];

   assign col_link[0]  = cand_x;
   assign near_link[0] = 1'b0;

   for (genvar i = 0; i < MAX_TIPS; i++) begin : g_cell
      cfpf_tip_cell #(
         .COORD_BITS(COORD_BITS)
      ) u_cell (
         .clock     (clock),
         .shift_en  (push),
         .active    (tip_count > CNT_BITS'(i)),
         .near_prev (near_link[i]),
         .prev_col  (col_link[i]),
         .cand_x    (cand_x),
         .min_sep   (min_sep),
         .next_col  (col_link[i+1]),
         .near_next (near_link[i+1])
      );
   end

   assign near = near_link[MAX_TIPS];

endmodule

[src/contour_fingertip_peak_finder.sv]
// ----------------------------------------------------------------------------
// contour_fingertip_peak_finder
// Tracks the farthest contour point from the palm center and turns held
// peaks into fingertips, kept in a short row of tip cells.
// ----------------------------------------------------------------------------
//  channel | ports        | payload
//  --------+--------------+---------------------------------------------
//  in      | req_t*       | tdata: point_x, point_y; tuser: new_contour
//  out     | rsp_t*       | tdata: tip_x, tip_y, tip_slot
//  config  | csr_*        | write only: index, data
//
// A word passes the steps accept, diff, square and update; a word that judges a
// peak also takes the judge step, the near test along the tip cells.
// The two 12x12 squares are registered before the sum and compare.
// A result waiting on rsp holds the judge cycle only when a new tip is ready.
// Reset clears peak, counter, tip count and loads the register defaults.
// ----------------------------------------------------------------------------
module contour_fingertip_peak_finder
   import cfpf_pkg::*;
#(
   parameter int MAX_TIPS   = 8,
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]     req_tdata,  // point_x, point_y
   input  logic                                  req_tuser,  // new_contour
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tip_x, tip_y, tip_slot
   output logic [((2*COORD_BITS+((MAX_TIPS > 1) ? $clog2(MAX_TIPS) : 1)+7)/8)*8-1:0]
                                                 rsp_tdata,
   input  logic                                  csr_we,
   input  csr_addr_type                          csr_addr,
   input  logic [((COORD_BITS > HOLD_BITS) ? COORD_BITS : HOLD_BITS)-1:0] csr_wdata
);

   localparam int W         = COORD_BITS;
   localparam int SLOT_BITS = (MAX_TIPS > 1) ? $clog2(MAX_TIPS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_TIPS + 1);
   localparam int DIST_BITS = 2 * W + 1;
   localparam int RSP_BITS  = ((2 * W + SLOT_BITS + 7) / 8) * 8;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIFF  = 3'd1;
   localparam logic [2:0] ST_SQ    = 3'd2;
   localparam logic [2:0] ST_UPD   = 3'd3;
   localparam logic [2:0] ST_JUDGE = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [W-1:0]         center_x_ff, center_x_in;
   logic [W-1:0]         center_y_ff, center_y_in;
   hold_type             hold_limit_ff, hold_limit_in;
   logic [W-1:0]         min_sep_ff, min_sep_in;

   logic [W-1:0]         px_ff, px_in;
   logic [W-1:0]         py_ff, py_in;
   logic                 nc_ff, nc_in;
   logic [W-1:0]         dx_ff, dx_in;
   logic [W-1:0]         dy_ff, dy_in;
   logic [2*W-1:0]       sqx_ff, sqx_in;
   logic [2*W-1:0]       sqy_ff, sqy_in;

   logic [DIST_BITS-1:0] peak_dist_ff, peak_dist_in;
   hold_type             hold_cnt_ff, hold_cnt_in;
   logic [W-1:0]         peak_x_ff, peak_x_in;
   logic [W-1:0]         peak_y_ff, peak_y_in;
   logic [CNT_BITS-1:0]  tip_count_ff, tip_count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         tip_x_ff, tip_x_in;
   logic [W-1:0]         tip_y_ff, tip_y_in;
   logic [SLOT_BITS-1:0] tip_slot_ff, tip_slot_in;

   logic [DIST_BITS-1:0] point_dist;
   logic [DIST_BITS-1:0] cur_peak;
   logic [DIST_BITS-1:0] new_peak;
   hold_type             cur_cnt;
   logic [HOLD_BITS:0]   next_cnt;
   logic [W-1:0]         base_x, base_y, new_x, new_y;
   logic                 near, full, push;

   // ---------------------------------------------------------------- config
   always_comb begin
      center_x_in   = center_x_ff;
      center_y_in   = center_y_ff;
      hold_limit_in = hold_limit_ff;
      min_sep_in    = min_sep_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_CENTER_X:       center_x_in   = csr_wdata[W-1:0];
            CSR_CENTER_Y:       center_y_in   = csr_wdata[W-1:0];
            CSR_HOLD_LIMIT:     hold_limit_in = csr_wdata[HOLD_BITS-1:0];
            CSR_MIN_SEPARATION: min_sep_in    = csr_wdata[W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- datapath
   assign point_dist = DIST_BITS'(sqx_ff) + DIST_BITS'(sqy_ff);
   assign cur_peak   = nc_ff ? '0 : peak_dist_ff;
   assign cur_cnt    = nc_ff ? '0 : hold_cnt_ff;
   assign base_x     = nc_ff ? px_ff : peak_x_ff;
   assign base_y     = nc_ff ? py_ff : peak_y_ff;
   assign new_peak   = (point_dist > cur_peak) ? point_dist : cur_peak;
   assign new_x      = (point_dist > cur_peak) ? px_ff : base_x;
   assign new_y      = (point_dist > cur_peak) ? py_ff : base_y;
   assign next_cnt   = {1'b0, cur_cnt} + (HOLD_BITS+1)'(1);

   assign full = tip_count_ff >= CNT_BITS'(MAX_TIPS);

   cfpf_tip_chain #(
      .MAX_TIPS  (MAX_TIPS),
      .COORD_BITS(W),
      .CNT_BITS  (CNT_BITS)
   ) u_chain (
      .clock     (clock),
      .push      (push),
      .tip_count (tip_count_ff),
      .cand_x    (peak_x_ff),
      .min_sep   (min_sep_ff),
      .near      (near)
   );

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      nc_in        = nc_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      peak_dist_in = peak_dist_ff;
      hold_cnt_in  = hold_cnt_ff;
      peak_x_in    = peak_x_ff;
      peak_y_in    = peak_y_ff;
      tip_count_in = tip_count_ff;
      tip_x_in     = tip_x_ff;
      tip_y_in     = tip_y_ff;
      tip_slot_in  = tip_slot_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      push         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               px_in    = req_tdata[W-1:0];
               py_in    = req_tdata[2*W-1:W];
               nc_in    = req_tuser;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dx_in    = (px_ff > center_x_ff) ? (px_ff - center_x_ff) : (center_x_ff - px_ff);
            dy_in    = (py_ff > center_y_ff) ? (py_ff - center_y_ff) : (center_y_ff - py_ff);
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sqx_in   = (2*W)'(dx_ff) * (2*W)'(dx_ff);
            sqy_in   = (2*W)'(dy_ff) * (2*W)'(dy_ff);
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (nc_ff) begin
               tip_count_in = '0;
            end
            peak_x_in    = new_x;
            peak_y_in    = new_y;
            peak_dist_in = new_peak;
            hold_cnt_in  = cur_cnt;
            state_in     = ST_IDLE;
            if (point_dist != new_peak) begin
               if (next_cnt <= {1'b0, hold_limit_ff}) begin
                  hold_cnt_in = next_cnt[HOLD_BITS-1:0];
               end else begin
                  // held peak is judged when its y is at most center_y; peak position stays for a rerun
                  hold_cnt_in  = '0;
                  peak_dist_in = '0;
                  if (new_y <= center_y_ff) begin
                     state_in = ST_JUDGE;
                  end
               end
            end
         end
         ST_JUDGE: begin
            if (near || full) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               push         = 1'b1;
               rsp_valid_in = 1'b1;
               tip_x_in     = peak_x_ff;
               tip_y_in     = peak_y_ff;
               tip_slot_in  = tip_count_ff[SLOT_BITS-1:0];
               tip_count_in = tip_count_ff + CNT_BITS'(1);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         hold_limit_ff <= HOLD_LIMIT_RESET;
         min_sep_ff    <= W'(MIN_SEP_RESET);
         peak_dist_ff  <= '0;
         hold_cnt_ff   <= '0;
         peak_x_ff     <= '0;
         peak_y_ff     <= '0;
         tip_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         center_x_ff   <= center_x_in;
         center_y_ff   <= center_y_in;
         hold_limit_ff <= hold_limit_in;
         min_sep_ff    <= min_sep_in;
         peak_dist_ff  <= peak_dist_in;
         hold_cnt_ff   <= hold_cnt_in;
         peak_x_ff     <= peak_x_in;
         peak_y_ff     <= peak_y_in;
         tip_count_ff  <= tip_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      nc_ff       <= nc_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      tip_x_ff    <= tip_x_in;
      tip_y_ff    <= tip_y_in;
      tip_slot_ff <= tip_slot_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({tip_slot_ff, tip_y_ff, tip_x_ff});

endmodule
